// File: hdl/pareto_nondominated_layer_sort_core_defines.svh
// Assertion macros for the layer sort core.
`ifndef PARETO_NONDOMINATED_LAYER_SORT_CORE_DEFINES_SVH
`define PARETO_NONDOMINATED_LAYER_SORT_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define PNLS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pnls: check failed");
`define PNLS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pnls: check failed");
`else
`define PNLS_ASSERT_IMP(lbl, ante, cons)
`define PNLS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hdl/pnls_pkg.sv
`default_nettype none

package pnls_pkg;

    localparam int DEF_MAX_POPULATION = 64;
    localparam int DEF_MAX_OBJECTIVES = 8;
    localparam int DEF_MAX_VIOLATIONS = 4;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 31;

    localparam logic [CFG_INDEX_W-1:0] CFG_OBJECTIVE_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VIOLATION_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EQUAL_TOLERANCE = 2'd2;

    localparam logic [3:0]  RST_OBJECTIVE_COUNT = 4'd2;
    localparam logic [2:0]  RST_VIOLATION_COUNT = 3'd0;
    localparam logic [30:0] RST_EQUAL_TOLERANCE = 31'd1;

    typedef struct packed {
        logic [5:0]         member;
        logic [2:0]         coordinate;
        logic               is_violation;
        logic signed [31:0] value;
        logic               last_value;
    } load_t;

    typedef struct packed {
        logic [5:0] sorted_member;
        logic [5:0] layer_index;
        logic       last_in_layer;
        logic       last_result;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/pareto_nondominated_layer_sort_core.sv
// Sorting: the load marked last_value starts the sort of all loaded members
//   into non-dominated layers.
// Throughput: one load request per cycle while idle; results are drained
//   layer by layer. No loads are taken during sort or drain.
// Reset: asynchronous active low; control and config registers return to
//   defaults. Stores and list memories are not cleared.
`default_nettype none
`include "pareto_nondominated_layer_sort_core_defines.svh"

module pareto_nondominated_layer_sort_core
    import pnls_pkg::*;
#(
    parameter int MAX_POPULATION = DEF_MAX_POPULATION,
    parameter int MAX_OBJECTIVES = DEF_MAX_OBJECTIVES,
    parameter int MAX_VIOLATIONS = DEF_MAX_VIOLATIONS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   load_valid,
    output logic                        load_stall,
    input  wire load_t                  load,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output result_t                     result
);

    // member index width, count width (holds MAX_POPULATION itself)
    localparam int MW   = (MAX_POPULATION > 1) ? $clog2(MAX_POPULATION) : 1;
    localparam int PW   = $clog2(MAX_POPULATION + 1);
    localparam int MAXQ = (MAX_OBJECTIVES > MAX_VIOLATIONS) ? MAX_OBJECTIVES : MAX_VIOLATIONS;
    localparam int QW   = $clog2(MAXQ + 1);
    localparam int OAW  = $clog2(MAX_POPULATION * MAX_OBJECTIVES);
    localparam int VAW  = $clog2(MAX_POPULATION * MAX_VIOLATIONS);
    localparam int EW   = 2 * MW + PW;   // layer entry: head, tail, size

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_LRD     = 5'd1;
    localparam logic [4:0] S_LCAP    = 5'd2;
    localparam logic [4:0] S_MEM     = 5'd3;
    localparam logic [4:0] S_CRD     = 5'd4;
    localparam logic [4:0] S_CEV     = 5'd5;
    localparam logic [4:0] S_APPLY   = 5'd6;
    localparam logic [4:0] S_PEND    = 5'd7;
    localparam logic [4:0] S_DECIDE  = 5'd8;
    localparam logic [4:0] S_NEWX    = 5'd9;
    localparam logic [4:0] S_PNEW    = 5'd10;
    localparam logic [4:0] S_PRD     = 5'd11;
    localparam logic [4:0] S_PMERGE  = 5'd12;
    localparam logic [4:0] S_INS_END = 5'd13;
    localparam logic [4:0] S_OLRD    = 5'd14;
    localparam logic [4:0] S_OLCAP   = 5'd15;
    localparam logic [4:0] S_OEMIT   = 5'd16;
    localparam logic [4:0] S_ONX     = 5'd17;

    // dominance verdict of stored member against the new individual
    localparam logic [1:0] DOM_NONE   = 2'd0;
    localparam logic [1:0] DOM_MEMBER = 2'd1;   // stored member dominates
    localparam logic [1:0] DOM_NEW    = 2'd2;   // new individual dominates

    // ---------------- configuration ----------------
    logic [3:0]  obj_count_reg;
    logic [2:0]  vio_count_reg;
    logic [30:0] tolerance_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            obj_count_reg <= RST_OBJECTIVE_COUNT;
            vio_count_reg <= RST_VIOLATION_COUNT;
            tolerance_reg <= RST_EQUAL_TOLERANCE;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_OBJECTIVE_COUNT: obj_count_reg <= cfg_data[3:0];
                CFG_VIOLATION_COUNT: vio_count_reg <= cfg_data[2:0];
                CFG_EQUAL_TOLERANCE: tolerance_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturated vector lengths
    logic [QW-1:0] obj_len;
    logic [QW-1:0] vio_len;
    assign obj_len = (32'(obj_count_reg) > MAX_OBJECTIVES) ? QW'(MAX_OBJECTIVES)
                                                           : QW'(obj_count_reg);
    assign vio_len = (32'(vio_count_reg) > MAX_VIOLATIONS) ? QW'(MAX_VIOLATIONS)
                                                           : QW'(vio_count_reg);

    // ---------------- control registers ----------------
    logic [4:0]    state_reg;
    logic [PW-1:0] pop_reg;
    logic [PW-1:0] x_reg;        // individual being inserted
    logic [PW-1:0] l_reg;        // current layer
    logic [PW-1:0] total_reg;    // layers in use
    logic [PW-1:0] placed_reg;   // members held in layers
    logic [MW-1:0] lh_reg, lt_reg;
    logic [PW-1:0] ls_reg, n_reg, i_reg;
    logic [MW-1:0] cur_reg, prev_reg;
    logic          has_prev_reg, free_reg;
    logic [MW-1:0] phead_reg, ptail_reg;
    logic [PW-1:0] psize_reg;
    logic          phase_reg;    // 0 violations, 1 objectives
    logic [QW-1:0] pos_reg;
    logic          all_same_reg, any_worse_reg, any_better_reg;
    logic [1:0]    dom_reg;
    logic [PW-1:0] count_reg;
    logic          result_valid_reg;
    result_t       result_reg;

    logic load_fire;
    assign load_stall = (state_reg != S_IDLE);
    assign load_fire  = load_valid && !load_stall;

    // ---------------- value stores ----------------
    logic signed [31:0] obj_mem [MAX_POPULATION*MAX_OBJECTIVES];
    logic signed [31:0] vio_mem [MAX_POPULATION*MAX_VIOLATIONS];
    logic signed [31:0] obj_qa, obj_qb, vio_qa, vio_qb;

    logic           ld_in_range;
    logic [MW-1:0]  ld_idx;
    logic [OAW-1:0] ld_oaddr, rd_oaddr_a, rd_oaddr_b;
    logic [VAW-1:0] ld_vaddr, rd_vaddr_a, rd_vaddr_b;
    logic [QW-1:0]  cur_len;
    logic           cmp_rd;

    assign ld_in_range = (7'(load.member) < 7'(MAX_POPULATION));
    assign ld_idx      = load.member[MW-1:0];
    assign ld_oaddr    = OAW'(OAW'(ld_idx) * OAW'(MAX_OBJECTIVES) + OAW'(load.coordinate));
    assign ld_vaddr    = VAW'(VAW'(ld_idx) * VAW'(MAX_VIOLATIONS) + VAW'(load.coordinate));
    assign rd_oaddr_a  = OAW'(OAW'(cur_reg) * OAW'(MAX_OBJECTIVES) + OAW'(pos_reg));
    assign rd_oaddr_b  = OAW'(OAW'(x_reg[MW-1:0]) * OAW'(MAX_OBJECTIVES) + OAW'(pos_reg));
    assign rd_vaddr_a  = VAW'(VAW'(cur_reg) * VAW'(MAX_VIOLATIONS) + VAW'(pos_reg));
    assign rd_vaddr_b  = VAW'(VAW'(x_reg[MW-1:0]) * VAW'(MAX_VIOLATIONS) + VAW'(pos_reg));
    assign cur_len     = phase_reg ? obj_len : vio_len;
    assign cmp_rd      = (state_reg == S_CRD) && (pos_reg != cur_len);

    always_ff @(posedge clk) begin
        if (load_fire && ld_in_range && !load.is_violation
            && (5'(load.coordinate) < 5'(MAX_OBJECTIVES)))
        begin
            obj_mem[ld_oaddr] <= load.value;
        end
        if (cmp_rd && phase_reg)
        begin
            obj_qa <= obj_mem[rd_oaddr_a];
            obj_qb <= obj_mem[rd_oaddr_b];
        end
    end

    always_ff @(posedge clk) begin
        if (load_fire && ld_in_range && load.is_violation
            && (5'(load.coordinate) < 5'(MAX_VIOLATIONS)))
        begin
            vio_mem[ld_vaddr] <= load.value;
        end
        if (cmp_rd && !phase_reg)
        begin
            vio_qa <= vio_mem[rd_vaddr_a];
            vio_qb <= vio_mem[rd_vaddr_b];
        end
    end

    // ---------------- list memories ----------------
    logic [MW-1:0] nxt_mem [MAX_POPULATION];
    logic [EW-1:0] ent_mem [MAX_POPULATION];
    logic [MW-1:0] nxt_q;
    logic [EW-1:0] ent_q;

    logic          nxt_we, nxt_re;
    logic [MW-1:0] nxt_wa, nxt_wd, nxt_ra;
    logic          ent_we, ent_re;
    logic [MW-1:0] ent_wa, ent_ra;
    logic [EW-1:0] ent_wd;

    always_ff @(posedge clk) begin
        if (nxt_we)
        begin
            nxt_mem[nxt_wa] <= nxt_wd;
        end
        if (nxt_re)
        begin
            nxt_q <= nxt_mem[nxt_ra];
        end
    end

    always_ff @(posedge clk) begin
        if (ent_we)
        begin
            ent_mem[ent_wa] <= ent_wd;
        end
        if (ent_re)
        begin
            ent_q <= ent_mem[ent_ra];
        end
    end

    logic [MW-1:0] e_head, e_tail;
    logic [PW-1:0] e_size;
    assign e_head = ent_q[EW-1 -: MW];
    assign e_tail = ent_q[PW+MW-1 -: MW];
    assign e_size = ent_q[PW-1:0];

    // ---------------- decision helpers ----------------
    logic [PW-1:0] l_plus1;
    logic          is_last_layer, room;
    logic [MW-1:0] x_idx;
    logic [1:0]    phase_verdict;
    logic          emit;

    assign l_plus1       = l_reg + PW'(1);
    assign is_last_layer = (l_plus1 == total_reg);
    assign room          = (total_reg < PW'(MAX_POPULATION));
    assign x_idx         = x_reg[MW-1:0];

    always_comb begin
        if (all_same_reg)
            phase_verdict = DOM_NONE;
        else if (!any_worse_reg)
            phase_verdict = DOM_MEMBER;
        else if (!any_better_reg)
            phase_verdict = DOM_NEW;
        else
            phase_verdict = DOM_NONE;
    end

    assign emit = (state_reg == S_OEMIT) && (i_reg != n_reg)
                  && (!result_valid_reg || !result_stall);

    // one compare step: difference exact in 34 bits
    logic signed [31:0] cmp_a, cmp_b;
    logic signed [33:0] diff, tol_s;
    logic               pos_same, pos_worse;
    assign cmp_a     = phase_reg ? obj_qa : vio_qa;
    assign cmp_b     = phase_reg ? obj_qb : vio_qb;
    assign diff      = 34'(cmp_a) - 34'(cmp_b);
    assign tol_s     = $signed({3'b000, tolerance_reg});
    assign pos_same  = (diff < tol_s) && (diff > -tol_s);
    assign pos_worse = !pos_same && (diff > 34'sd0);

    // memory port control
    always_comb begin
        nxt_we = 1'b0;
        nxt_wa = prev_reg;
        nxt_wd = nxt_q;
        nxt_re = 1'b0;
        nxt_ra = cur_reg;
        ent_we = 1'b0;
        ent_wa = l_reg[MW-1:0];
        ent_wd = {lh_reg, lt_reg, ls_reg};
        ent_re = 1'b0;
        ent_ra = l_reg[MW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (load_fire && load.last_value)
                begin
                    // layer 0 starts empty
                    ent_we = 1'b1;
                    ent_wa = '0;
                    ent_wd = '0;
                end
            end
            S_LRD, S_OLCAP:
            begin
                ent_re = (state_reg == S_LRD);
            end
            S_OLRD:
            begin
                ent_re = (l_reg != total_reg);
            end
            S_MEM:
            begin
                nxt_re = (i_reg != n_reg);
            end
            S_APPLY:
            begin
                // unlink from layer
                nxt_we = (dom_reg == DOM_NEW) && has_prev_reg;
            end
            S_PEND:
            begin
                nxt_we = (psize_reg != '0);
                nxt_wa = ptail_reg;
                nxt_wd = cur_reg;
            end
            S_DECIDE:
            begin
                if (!free_reg && !is_last_layer)
                begin
                    ent_we = 1'b1;
                end
                else if (free_reg)
                begin
                    nxt_we = (ls_reg != '0);
                    nxt_wa = lt_reg;
                    nxt_wd = x_idx;
                    ent_we = 1'b1;
                    ent_wd = {(ls_reg == '0) ? x_idx : lh_reg, x_idx, ls_reg + PW'(1)};
                end
                else
                begin
                    ent_we = 1'b1;
                end
            end
            S_NEWX:
            begin
                ent_we = room;
                ent_wa = total_reg[MW-1:0];
                ent_wd = {x_idx, x_idx, PW'(1)};
            end
            S_PNEW:
            begin
                ent_we = room && (psize_reg != '0);
                ent_wa = total_reg[MW-1:0];
                ent_wd = {phead_reg, ptail_reg, psize_reg};
            end
            S_PRD:
            begin
                ent_re = 1'b1;
                ent_ra = l_plus1[MW-1:0];
            end
            S_PMERGE:
            begin
                nxt_we = (e_size != '0);
                nxt_wa = e_tail;
                nxt_wd = phead_reg;
                ent_we = 1'b1;
                ent_wa = l_plus1[MW-1:0];
                ent_wd = {(e_size == '0) ? phead_reg : e_head, ptail_reg,
                          e_size + psize_reg};
            end
            S_OEMIT:
            begin
                nxt_re = emit;
            end
            default: ;
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pop_reg        <= '0;
            x_reg          <= '0;
            l_reg          <= '0;
            total_reg      <= '0;
            placed_reg     <= '0;
            lh_reg         <= '0;
            lt_reg         <= '0;
            ls_reg         <= '0;
            n_reg          <= '0;
            i_reg          <= '0;
            cur_reg        <= '0;
            prev_reg       <= '0;
            has_prev_reg   <= 1'b0;
            free_reg       <= 1'b1;
            phead_reg      <= '0;
            ptail_reg      <= '0;
            psize_reg      <= '0;
            phase_reg      <= 1'b0;
            pos_reg        <= '0;
            all_same_reg   <= 1'b1;
            any_worse_reg  <= 1'b0;
            any_better_reg <= 1'b0;
            dom_reg        <= DOM_NONE;
            count_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (load_fire && load.last_value)
                    begin
                        pop_reg    <= ld_in_range ? PW'(7'(load.member) + 7'd1)
                                                  : PW'(MAX_POPULATION);
                        total_reg  <= PW'(1);
                        placed_reg <= '0;
                        x_reg      <= '0;
                        l_reg      <= '0;
                        psize_reg  <= '0;
                        state_reg  <= S_LRD;
                    end
                end
                S_LRD:
                begin
                    state_reg <= S_LCAP;
                end
                S_LCAP:
                begin
                    lh_reg       <= e_head;
                    lt_reg       <= e_tail;
                    ls_reg       <= e_size;
                    n_reg        <= e_size;
                    cur_reg      <= e_head;
                    prev_reg     <= '0;
                    has_prev_reg <= 1'b0;
                    free_reg     <= 1'b1;
                    i_reg        <= '0;
                    state_reg    <= S_MEM;
                end
                S_MEM:
                begin
                    if (i_reg == n_reg)
                    begin
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        phase_reg      <= 1'b0;
                        pos_reg        <= '0;
                        all_same_reg   <= 1'b1;
                        any_worse_reg  <= 1'b0;
                        any_better_reg <= 1'b0;
                        state_reg      <= S_CRD;
                    end
                end
                S_CRD:
                begin
                    if (pos_reg == cur_len)
                    begin
                        if (!phase_reg && (phase_verdict == DOM_NONE))
                        begin
                            // no dominance on violations: go on to objectives
                            phase_reg      <= 1'b1;
                            pos_reg        <= '0;
                            all_same_reg   <= 1'b1;
                            any_worse_reg  <= 1'b0;
                            any_better_reg <= 1'b0;
                        end
                        else
                        begin
                            dom_reg   <= phase_verdict;
                            state_reg <= S_APPLY;
                        end
                    end
                    else
                    begin
                        state_reg <= S_CEV;
                    end
                end
                S_CEV:
                begin
                    if (!pos_same)
                    begin
                        all_same_reg <= 1'b0;
                    end
                    if (pos_worse)
                    begin
                        any_worse_reg <= 1'b1;
                    end
                    if (!pos_same && !pos_worse)
                    begin
                        any_better_reg <= 1'b1;
                    end
                    pos_reg   <= pos_reg + QW'(1);
                    state_reg <= S_CRD;
                end
                S_APPLY:
                begin
                    if (dom_reg == DOM_MEMBER)
                    begin
                        free_reg <= 1'b0;
                    end
                    if (dom_reg == DOM_NEW)
                    begin
                        if (!has_prev_reg)
                        begin
                            lh_reg <= nxt_q;
                        end
                        if (lt_reg == cur_reg)
                        begin
                            lt_reg <= prev_reg;
                        end
                        ls_reg    <= ls_reg - PW'(1);
                        state_reg <= S_PEND;
                    end
                    else
                    begin
                        prev_reg     <= cur_reg;
                        has_prev_reg <= 1'b1;
                        cur_reg      <= nxt_q;
                        i_reg        <= i_reg + PW'(1);
                        state_reg    <= S_MEM;
                    end
                end
                S_PEND:
                begin
                    if (psize_reg == '0)
                    begin
                        phead_reg <= cur_reg;
                    end
                    ptail_reg <= cur_reg;
                    psize_reg <= psize_reg + PW'(1);
                    cur_reg   <= nxt_q;
                    i_reg     <= i_reg + PW'(1);
                    state_reg <= S_MEM;
                end
                S_DECIDE:
                begin
                    if (!free_reg && !is_last_layer)
                    begin
                        l_reg     <= l_plus1;
                        state_reg <= S_LRD;
                    end
                    else if (free_reg)
                    begin
                        placed_reg <= placed_reg + PW'(1);
                        if (is_last_layer)
                            state_reg <= S_PNEW;
                        else if (psize_reg != '0)
                            state_reg <= S_PRD;
                        else
                            state_reg <= S_INS_END;
                    end
                    else
                    begin
                        state_reg <= S_NEWX;
                    end
                end
                S_NEWX:
                begin
                    if (room)
                    begin
                        total_reg  <= total_reg + PW'(1);
                        placed_reg <= placed_reg + PW'(1);
                    end
                    state_reg <= S_PNEW;
                end
                S_PNEW:
                begin
                    if (psize_reg != '0)
                    begin
                        if (room)
                            total_reg <= total_reg + PW'(1);
                        else
                            placed_reg <= placed_reg - psize_reg;   // dropped
                    end
                    psize_reg <= '0;
                    state_reg <= S_INS_END;
                end
                S_PRD:
                begin
                    state_reg <= S_PMERGE;
                end
                S_PMERGE:
                begin
                    psize_reg <= '0;
                    state_reg <= S_INS_END;
                end
                S_INS_END:
                begin
                    x_reg     <= x_reg + PW'(1);
                    l_reg     <= '0;
                    psize_reg <= '0;
                    count_reg <= '0;
                    if (x_reg + PW'(1) == pop_reg)
                        state_reg <= S_OLRD;
                    else
                        state_reg <= S_LRD;
                end
                S_OLRD:
                begin
                    if (l_reg == total_reg)
                        state_reg <= S_IDLE;
                    else
                        state_reg <= S_OLCAP;
                end
                S_OLCAP:
                begin
                    cur_reg   <= e_head;
                    n_reg     <= e_size;
                    i_reg     <= '0;
                    state_reg <= S_OEMIT;
                end
                S_OEMIT:
                begin
                    if (i_reg == n_reg)
                    begin
                        l_reg     <= l_plus1;
                        state_reg <= S_OLRD;
                    end
                    else if (emit)
                    begin
                        count_reg <= count_reg + PW'(1);
                        state_reg <= S_ONX;
                    end
                end
                S_ONX:
                begin
                    cur_reg   <= nxt_q;
                    i_reg     <= i_reg + PW'(1);
                    state_reg <= S_OEMIT;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (emit)
        begin
            result_reg.sorted_member <= 6'(cur_reg);
            result_reg.layer_index   <= 6'(l_reg);
            result_reg.last_in_layer <= (i_reg + PW'(1) == n_reg);
            result_reg.last_result   <= (count_reg + PW'(1) == placed_reg);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------- checks ----------------
    `PNLS_ASSERT_IMP(a_total_bound, 1'b1, total_reg <= PW'(MAX_POPULATION))
    `PNLS_ASSERT_IMP(a_emit_bound, emit, count_reg < placed_reg)
    `PNLS_ASSERT_NEXT(a_pend_grows, state_reg == S_PEND, psize_reg != '0)

endmodule

`default_nettype wire
